// ===== hdl/hts_pkg.sv =====
// Shared types, constants and helper functions for the heightmap triangle sampler.
// Every other file of the block refers to this package by scoped names.
package hts_pkg;

  localparam int MAP_SIZE    = 256;
  localparam int CELL_W      = $clog2(MAP_SIZE);
  localparam int MAP_W       = $clog2(MAP_SIZE + 1);
  localparam int T_W         = 32 + MAP_W;
  localparam int IDX_W       = CELL_W + MAP_W + 1;
  localparam int STORE_DEPTH = 65536;
  localparam int STORE_AW    = 16;
  localparam int NUM_BANKS   = 4;

  localparam int FQ_DEPTH = 8;
  localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
  localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

  localparam int APB_AW = 4;

  localparam logic [1:0] REG_EXTENT = 2'd0;
  localparam logic [1:0] REG_INV    = 2'd1;
  localparam logic [1:0] REG_VSCALE = 2'd2;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [30:0] EXTENT_RST = 31'd65536;
  localparam logic [31:0] INV_RST    = 32'hFFFF_FFFF;
  localparam logic [31:0] VSCALE_RST = 32'd65536;

  typedef struct packed {
    logic [30:0] extent;
    logic [31:0] inv;
    logic [31:0] vscale;
  } cfg_t;

  typedef struct packed {
    logic                func;
    logic [CELL_W-1:0]   cell_x;
    logic [15:0]         frac_u;
    logic [CELL_W-1:0]   cell_z;
    logic [15:0]         frac_v;
    logic [STORE_AW-1:0] sample_addr;
    logic [15:0]         sample_value;
  } item_t;

  function automatic logic [CELL_W-1:0] next_cell(input logic [CELL_W-1:0] c);
    logic [CELL_W-1:0] r;
    if (c == CELL_W'(MAP_SIZE - 1)) begin
      r = '0;
    end else begin
      r = c + 1'b1;
    end
    return r;
  endfunction

  // The store index wraps modulo the store depth.
  function automatic logic [STORE_AW-1:0] store_index(input logic [CELL_W-1:0] row,
                                                      input logic [CELL_W-1:0] col);
    logic [IDX_W-1:0] full_idx;
    full_idx = IDX_W'(row) * IDX_W'(MAP_SIZE) + IDX_W'(col);
    return STORE_AW'(full_idx);
  endfunction

endpackage

// ===== hdl/hts_cfg_regs.sv =====
// APB-style configuration registers: extent, inverse extent and vertical scale.
// Depends on hts_pkg for register indexes, reset values and cfg_t.
module hts_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hts_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output hts_pkg::cfg_t               cfg
);

  logic [30:0] extent_r;
  logic [31:0] inv_r;
  logic [31:0] vscale_r;
  logic        wr_en;
  logic [1:0]  reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extent_r <= hts_pkg::EXTENT_RST;
      inv_r    <= hts_pkg::INV_RST;
      vscale_r <= hts_pkg::VSCALE_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        hts_pkg::REG_EXTENT: extent_r <= pwdata[30:0];
        hts_pkg::REG_INV:    inv_r    <= pwdata;
        hts_pkg::REG_VSCALE: vscale_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      hts_pkg::REG_EXTENT: prdata = {1'b0, extent_r};
      hts_pkg::REG_INV:    prdata = inv_r;
      hts_pkg::REG_VSCALE: prdata = vscale_r;
      default:             prdata = '0;
    endcase
  end

  assign cfg.extent = extent_r;
  assign cfg.inv    = inv_r;
  assign cfg.vscale = vscale_r;

endmodule

// ===== hdl/hts_front.sv =====
// Front end: accepts beats, offsets and normalizes query points, maps them to cells.
// Depends on hts_pkg; pushes finished items into the hts_queue between front and back.
module hts_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic                          in_func,
  input  logic [31:0]                   in_pos_x,
  input  logic [31:0]                   in_pos_z,
  input  logic [15:0]                   in_sample_addr,
  input  logic [15:0]                   in_sample_value,
  input  hts_pkg::cfg_t                 cfg,
  input  logic [hts_pkg::FQ_CNT_W-1:0]  fq_count,
  output logic                          fq_push,
  output hts_pkg::item_t                fq_item
);

  logic                        accept;
  logic [hts_pkg::FQ_CNT_W:0]  occupancy;

  logic        va_r, vb_r, vc_r;
  logic        func_a_r, func_b_r, func_c_r;
  logic [31:0] pos_x_a_r, pos_z_a_r;
  logic [15:0] addr_a_r, addr_b_r, addr_c_r;
  logic [15:0] value_a_r, value_b_r, value_c_r;
  logic [32:0] s_x_nxt, s_z_nxt, s_x_b_r, s_z_b_r;
  logic signed [65:0] p_x, p_z;
  logic [31:0] f_x_nxt, f_z_nxt, f_x_c_r, f_z_c_r;
  logic [hts_pkg::T_W-1:0] t_x, t_z;

  assign occupancy = (hts_pkg::FQ_CNT_W + 1)'(fq_count) + (hts_pkg::FQ_CNT_W + 1)'(va_r)
                   + (hts_pkg::FQ_CNT_W + 1)'(vb_r) + (hts_pkg::FQ_CNT_W + 1)'(vc_r);
  assign full   = occupancy >= (hts_pkg::FQ_CNT_W + 1)'(hts_pkg::FQ_DEPTH);
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      va_r <= accept;
      vb_r <= va_r;
      vc_r <= vb_r;
    end
  end

  // The point is offset by half the extent; the sum is exact in 33 bits.
  assign s_x_nxt = {pos_x_a_r[31], pos_x_a_r} + {3'b000, cfg.extent[30:1]};
  assign s_z_nxt = {pos_z_a_r[31], pos_z_a_r} + {3'b000, cfg.extent[30:1]};

  // Only the low 48 bits of the product matter, so the wrapped fraction is bits 47..16.
  assign p_x     = $signed(s_x_b_r) * $signed({1'b0, cfg.inv});
  assign p_z     = $signed(s_z_b_r) * $signed({1'b0, cfg.inv});
  assign f_x_nxt = p_x[47:16];
  assign f_z_nxt = p_z[47:16];

  always_ff @(posedge clk) begin
    if (accept) begin
      func_a_r  <= in_func;
      pos_x_a_r <= in_pos_x;
      pos_z_a_r <= in_pos_z;
      addr_a_r  <= in_sample_addr;
      value_a_r <= in_sample_value;
    end
    func_b_r  <= func_a_r;
    s_x_b_r   <= s_x_nxt;
    s_z_b_r   <= s_z_nxt;
    addr_b_r  <= addr_a_r;
    value_b_r <= value_a_r;
    func_c_r  <= func_b_r;
    f_x_c_r   <= f_x_nxt;
    f_z_c_r   <= f_z_nxt;
    addr_c_r  <= addr_b_r;
    value_c_r <= value_b_r;
  end

  assign t_x = hts_pkg::T_W'(f_x_c_r) * hts_pkg::T_W'(hts_pkg::MAP_SIZE);
  assign t_z = hts_pkg::T_W'(f_z_c_r) * hts_pkg::T_W'(hts_pkg::MAP_SIZE);

  assign fq_push              = vc_r;
  assign fq_item.func         = func_c_r;
  assign fq_item.cell_x       = t_x[32 +: hts_pkg::CELL_W];
  assign fq_item.frac_u       = t_x[31:16];
  assign fq_item.cell_z       = t_z[32 +: hts_pkg::CELL_W];
  assign fq_item.frac_v       = t_z[31:16];
  assign fq_item.sample_addr  = addr_c_r;
  assign fq_item.sample_value = value_c_r;

  a_front_credit: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= (hts_pkg::FQ_CNT_W + 1)'(hts_pkg::FQ_DEPTH))
    else $error("front items in flight exceed queue space");

endmodule

// ===== hdl/hts_queue.sv =====
// Short queue of classified items between the front end and the back end.
// Depends on hts_pkg for item_t and the queue depth.
module hts_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  input  hts_pkg::item_t                item_in,
  input  logic                          pop,
  output hts_pkg::item_t                item_out,
  output logic                          empty,
  output logic [hts_pkg::FQ_CNT_W-1:0]  count
);

  hts_pkg::item_t                 q_mem [hts_pkg::FQ_DEPTH];
  logic [hts_pkg::FQ_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [hts_pkg::FQ_CNT_W-1:0]   count_r, count_nxt;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == hts_pkg::FQ_PTR_W'(hts_pkg::FQ_DEPTH - 1)) ? '0
                                                                             : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == hts_pkg::FQ_PTR_W'(hts_pkg::FQ_DEPTH - 1)) ? '0
                                                                             : rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= item_in;
    end
  end

  assign item_out = q_mem[rd_ptr_r];
  assign empty    = (count_r == '0);
  assign count    = count_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> count_r < hts_pkg::FQ_CNT_W'(hts_pkg::FQ_DEPTH))
    else $error("item queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> count_r != '0)
    else $error("item queue read while empty");

endmodule

// ===== hdl/hts_back.sv =====
// Back end: banked heightmap store, triangle interpolation, scaling and result queue.
// Depends on hts_pkg; takes items from hts_queue and drives the result channel.
module hts_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [31:0]          vscale,
  input  logic                 fq_empty,
  input  hts_pkg::item_t       fq_item,
  output logic                 fq_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [31:0]          out_height_out
);

  logic                            vd_r, q_d;
  hts_pkg::item_t                  item_d_r;
  logic                            wr_en;
  logic [hts_pkg::CELL_W-1:0]      x1, z1;
  logic [hts_pkg::STORE_AW-1:0]    rd_idx [hts_pkg::NUM_BANKS];
  logic [15:0]                     rd_data_r [hts_pkg::NUM_BANKS];

  logic                            q_e_r, q_f_r, q_g_r, q_h_r, q_i_r;
  logic [15:0]                     u_e_r, v_e_r, u_f_r, v_f_r;
  logic signed [15:0]              h0_e, h1_e, h2_e, h3_e, h0_f_r, h0_g_r;
  logic signed [16:0]              du_nxt, dv_nxt, du_f_r, dv_f_r;
  logic signed [33:0]              pu_nxt, pv_nxt, pu_g_r, pv_g_r;
  logic signed [34:0]              acc;
  logic signed [26:0]              q16_h_r;
  logic signed [58:0]              prod_nxt, prod_i_r;
  logic signed [42:0]              res;
  logic [31:0]                     sat;

  logic [31:0]                     oq_mem [hts_pkg::OQ_DEPTH];
  logic [hts_pkg::OQ_PTR_W-1:0]    oq_wr_r, oq_rd_r;
  logic [hts_pkg::OQ_CNT_W-1:0]    oq_count_r, oq_count_nxt;
  logic [hts_pkg::OQ_CNT_W:0]      occupancy;
  logic                            out_take;

  assign q_d = vd_r && (item_d_r.func == hts_pkg::FUNC_QUERY);

  // A query is taken only when the result queue is sure to have room for it.
  assign occupancy = (hts_pkg::OQ_CNT_W + 1)'(oq_count_r) + (hts_pkg::OQ_CNT_W + 1)'(q_d)
                   + (hts_pkg::OQ_CNT_W + 1)'(q_e_r) + (hts_pkg::OQ_CNT_W + 1)'(q_f_r)
                   + (hts_pkg::OQ_CNT_W + 1)'(q_g_r) + (hts_pkg::OQ_CNT_W + 1)'(q_h_r)
                   + (hts_pkg::OQ_CNT_W + 1)'(q_i_r);
  assign fq_pop = !fq_empty && (occupancy < (hts_pkg::OQ_CNT_W + 1)'(hts_pkg::OQ_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r  <= 1'b0;
      q_e_r <= 1'b0;
      q_f_r <= 1'b0;
      q_g_r <= 1'b0;
      q_h_r <= 1'b0;
      q_i_r <= 1'b0;
    end else begin
      vd_r  <= fq_pop;
      q_e_r <= q_d;
      q_f_r <= q_e_r;
      q_g_r <= q_f_r;
      q_h_r <= q_g_r;
      q_i_r <= q_h_r;
    end
  end

  // Each bank holds a full copy of the heightmap so that all four neighbors read at once.
  assign wr_en     = vd_r && (item_d_r.func == hts_pkg::FUNC_LOAD);
  assign x1        = hts_pkg::next_cell(item_d_r.cell_x);
  assign z1        = hts_pkg::next_cell(item_d_r.cell_z);
  assign rd_idx[0] = hts_pkg::store_index(item_d_r.cell_z, item_d_r.cell_x);
  assign rd_idx[1] = hts_pkg::store_index(item_d_r.cell_z, x1);
  assign rd_idx[2] = hts_pkg::store_index(z1, item_d_r.cell_x);
  assign rd_idx[3] = hts_pkg::store_index(z1, x1);

  for (genvar b = 0; b < hts_pkg::NUM_BANKS; b++) begin : g_bank
    logic [15:0] bank_mem [hts_pkg::STORE_DEPTH];

    always_ff @(posedge clk) begin
      if (wr_en) begin
        bank_mem[item_d_r.sample_addr] <= item_d_r.sample_value;
      end
      rd_data_r[b] <= bank_mem[rd_idx[b]];
    end
  end

  assign h0_e = $signed(rd_data_r[0]);
  assign h1_e = $signed(rd_data_r[1]);
  assign h2_e = $signed(rd_data_r[2]);
  assign h3_e = $signed(rd_data_r[3]);

  always_comb begin
    if (u_e_r > v_e_r) begin
      du_nxt = h1_e - h0_e;
      dv_nxt = h3_e - h1_e;
    end else begin
      du_nxt = h3_e - h2_e;
      dv_nxt = h2_e - h0_e;
    end
  end

  assign pu_nxt   = du_f_r * $signed({1'b0, u_f_r});
  assign pv_nxt   = dv_f_r * $signed({1'b0, v_f_r});
  assign acc      = $signed({h0_g_r, 16'h0000}) + pu_g_r + pv_g_r;
  assign prod_nxt = q16_h_r * $signed(vscale);
  assign res      = prod_i_r[58:16];

  always_comb begin
    priority if (!res[42] && (|res[41:31])) begin
      sat = 32'h7FFF_FFFF;
    end else if (res[42] && !(&res[41:31])) begin
      sat = 32'h8000_0000;
    end else begin
      sat = res[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (fq_pop) begin
      item_d_r <= fq_item;
    end
    u_e_r    <= item_d_r.frac_u;
    v_e_r    <= item_d_r.frac_v;
    h0_f_r   <= h0_e;
    du_f_r   <= du_nxt;
    dv_f_r   <= dv_nxt;
    u_f_r    <= u_e_r;
    v_f_r    <= v_e_r;
    h0_g_r   <= h0_f_r;
    pu_g_r   <= pu_nxt;
    pv_g_r   <= pv_nxt;
    q16_h_r  <= acc[34:8];
    prod_i_r <= prod_nxt;
  end

  assign out_take = out_pop && !out_empty;

  always_comb begin
    oq_count_nxt = oq_count_r;
    if (q_i_r && !out_take) begin
      oq_count_nxt = oq_count_r + 1'b1;
    end else if (out_take && !q_i_r) begin
      oq_count_nxt = oq_count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wr_r    <= '0;
      oq_rd_r    <= '0;
      oq_count_r <= '0;
    end else begin
      oq_count_r <= oq_count_nxt;
      if (q_i_r) begin
        oq_wr_r <= (oq_wr_r == hts_pkg::OQ_PTR_W'(hts_pkg::OQ_DEPTH - 1)) ? '0
                                                                           : oq_wr_r + 1'b1;
      end
      if (out_take) begin
        oq_rd_r <= (oq_rd_r == hts_pkg::OQ_PTR_W'(hts_pkg::OQ_DEPTH - 1)) ? '0
                                                                           : oq_rd_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_i_r) begin
      oq_mem[oq_wr_r] <= sat;
    end
  end

  assign out_empty      = (oq_count_r == '0);
  assign out_height_out = oq_mem[oq_rd_r];

  a_result_credit: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= (hts_pkg::OQ_CNT_W + 1)'(hts_pkg::OQ_DEPTH))
    else $error("queries in flight exceed result queue space");

  a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_i_r |-> oq_count_r < hts_pkg::OQ_CNT_W'(hts_pkg::OQ_DEPTH))
    else $error("result written into a full result queue");

endmodule

// ===== hdl/heightmap_triangle_sampler_top.sv =====
// Top level of the heightmap triangle sampler: registers, front end, item queue, back end.
// Depends on hts_pkg, hts_cfg_regs, hts_front, hts_queue and hts_back.
//
// Use: the input channel is a queue interface. A beat is taken at a rising edge with push
// high and full low. A load beat (func 0) writes sample_value at sample_addr; a query beat
// (func 1) carries a Q16.16 world point and yields one Q16.16 height. The result channel is
// the read side of a queue: while empty is low the oldest height sits on out_height_out and
// is taken at an edge with pop high. Results come out in the order of the query beats.
// The user must write registers over the APB-style port only while no beat is in flight;
// the block itself does not enforce this. One beat is taken per cycle while full is low,
// loads and queries mixed in any order; the four neighbor samples come from four copies
// of the heightmap, one read port each. If the receiver holds pop low, the result queue
// fills, the back end stops taking items, and full rises once the item queue and front
// pipeline are taken up; nothing is lost.
// Reset clears the pipelines and both queues and sets the registers to their reset values.
// The heightmap itself is not cleared: a sample must be loaded before a query reads it.
module heightmap_triangle_sampler_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        full,
  input  logic                        in_func,
  input  logic [31:0]                 in_pos_x,
  input  logic [31:0]                 in_pos_z,
  input  logic [15:0]                 in_sample_addr,
  input  logic [15:0]                 in_sample_value,
  output logic                        empty,
  input  logic                        pop,
  output logic [31:0]                 out_height_out,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [hts_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  hts_pkg::cfg_t                  cfg;
  logic                           fq_push, fq_pop, fq_empty;
  hts_pkg::item_t                 fq_item_in, fq_item_out;
  logic [hts_pkg::FQ_CNT_W-1:0]   fq_count;

  hts_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hts_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_func         (in_func),
    .in_pos_x        (in_pos_x),
    .in_pos_z        (in_pos_z),
    .in_sample_addr  (in_sample_addr),
    .in_sample_value (in_sample_value),
    .cfg             (cfg),
    .fq_count        (fq_count),
    .fq_push         (fq_push),
    .fq_item         (fq_item_in)
  );

  hts_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fq_push),
    .item_in  (fq_item_in),
    .pop      (fq_pop),
    .item_out (fq_item_out),
    .empty    (fq_empty),
    .count    (fq_count)
  );

  hts_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .vscale         (cfg.vscale),
    .fq_empty       (fq_empty),
    .fq_item        (fq_item_out),
    .fq_pop         (fq_pop),
    .out_empty      (empty),
    .out_pop        (pop),
    .out_height_out (out_height_out)
  );

endmodule
